// ----- sv/segtree_pkg.sv -----
// Shared types, constants and combining functions for the segment tree block.
// No dependencies; imported by segtree_fold and the top module of the block.
package segtree_pkg;

   localparam int DATA_W      = 64;
   localparam int POS_W       = 10;
   localparam int MODE_W      = 2;
   localparam int REQ_DATA_W  = 88;
   localparam int RSP_DATA_W  = 64;
   localparam int POS_LSB     = 0;
   localparam int RIGHT_LSB   = 10;
   localparam int VALUE_LSB   = 20;
   localparam int DEF_LEAVES  = 1024;

   localparam logic [MODE_W-1:0] MODE_SUM = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MIN = 2'd2;

   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_LEAF,
      ST_UPD_WALK,
      ST_QRY_WALK,
      ST_QRY_DRAIN,
      ST_QRY_OUT
   } state_type;

   typedef struct packed {
      logic init;
      logic run;
      logic take_a;
      logic take_b;
   } fold_ctl_type;

   function automatic logic [DATA_W-1:0] seg_identity(logic [MODE_W-1:0] mode);
      logic [DATA_W-1:0] id;
      case (mode)
         MODE_MAX: id = {1'b1, {(DATA_W-1){1'b0}}};
         MODE_MIN: id = {1'b0, {(DATA_W-1){1'b1}}};
         default:  id = '0;
      endcase
      return id;
   endfunction

   function automatic logic [DATA_W-1:0] seg_combine(logic [MODE_W-1:0] mode,
                                                     logic [DATA_W-1:0] a,
                                                     logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] res;
      case (mode)
         MODE_MAX: res = ($signed(a) < $signed(b)) ? b : a;
         MODE_MIN: res = ($signed(b) < $signed(a)) ? b : a;
         default:  res = a + b;
      endcase
      return res;
   endfunction

endpackage

// ----- sv/segtree_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// Depends on nothing.
module segtree_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ----- sv/segtree_fold.sv -----
// Query accumulator: pairs the two node reads of one level, then folds the pair
// into the running result. Depends on segtree_pkg.
module segtree_fold
   import segtree_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  fold_ctl_type        ctl,
   input  logic [MODE_W-1:0]   mode,
   input  logic [DATA_W-1:0]   rd_data_a,
   input  logic [DATA_W-1:0]   rd_data_b,
   output logic [DATA_W-1:0]   acc
);

   logic              take_a_ff;
   logic              take_b_ff;
   logic [DATA_W-1:0] pair_ff;
   logic [DATA_W-1:0] acc_ff;
   logic [DATA_W-1:0] ident;
   logic [DATA_W-1:0] sel_a;
   logic [DATA_W-1:0] sel_b;

   always_comb begin
      ident = seg_identity(mode);
      sel_a = take_a_ff ? rd_data_a : ident;
      sel_b = take_b_ff ? rd_data_b : ident;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         take_a_ff <= 1'b0;
         take_b_ff <= 1'b0;
      end else if (ctl.init) begin
         take_a_ff <= 1'b0;
         take_b_ff <= 1'b0;
      end else if (ctl.run) begin
         take_a_ff <= ctl.take_a;
         take_b_ff <= ctl.take_b;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.init) begin
         pair_ff <= ident;
         acc_ff  <= ident;
      end else if (ctl.run) begin
         pair_ff <= seg_combine(mode, sel_a, sel_b);
         acc_ff  <= seg_combine(mode, acc_ff, pair_ff);
      end
   end

   assign acc = acc_ff;

endmodule

// ----- sv/segment_tree_point_update_range_query.sv -----
// Channel | dir | handshake          | payload
// req     | in  | req_tvalid/tready  | tuser: kind; tdata: position, right_end, value
// rsp     | out | rsp_tvalid/tready  | tdata: answer
// csr     | in  | csr_valid/ready    | csr_wdata: combine_mode
// Update: the leaf is written, then one tree level per cycle up to the root through
// the node memory's single write port. Query: both ends of a level are read at once,
// then a two-stage fold.
// After reset a clearing pass zeroes the node memory with req_tready low.
// One transaction in work at a time; a finished answer waits in the output register.
// Depends on segtree_pkg, segtree_ram, segtree_fold.
module segment_tree_point_update_range_query
   import segtree_pkg::*;
#(
   parameter int LEAVES = DEF_LEAVES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // position[9:0], right_end[19:10], value[83:20]
   input  logic                  req_tuser,  // kind[0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // answer[63:0]
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [MODE_W-1:0]     csr_wdata
);

   localparam int DEPTH = 2 * LEAVES;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [AW-1:0]     node_ff, node_in;
   logic [DATA_W-1:0] cur_ff, cur_in;
   logic [NW-1:0]     lo_ff, lo_in;
   logic [NW-1:0]     hi_ff, hi_in;
   logic              drain_ff, drain_in;
   logic [MODE_W-1:0] mode_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic [AW-1:0]     ram_raddr_a;
   logic [AW-1:0]     ram_raddr_b;
   logic [DATA_W-1:0] ram_rdata_a;
   logic [DATA_W-1:0] ram_rdata_b;
   fold_ctl_type      fold_ctl;
   logic [DATA_W-1:0] fold_acc;

   logic              req_fire;
   logic [31:0]       pos32;
   logic [31:0]       right32;
   logic [31:0]       rsat32;
   logic [AW-1:0]     parent;
   logic [DATA_W-1:0] upd_res;
   logic [NW-1:0]     lo_inc;
   logic [NW-1:0]     hi_dec;
   logic [NW-1:0]     lo_nx;
   logic [NW-1:0]     hi_nx;

   segtree_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_nodes (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr_a (ram_raddr_a),
      .rd_data_a (ram_rdata_a),
      .rd_addr_b (ram_raddr_b),
      .rd_data_b (ram_rdata_b)
   );

   segtree_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fold_ctl),
      .mode      (mode_ff),
      .rd_data_a (ram_rdata_a),
      .rd_data_b (ram_rdata_b),
      .acc       (fold_acc)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      pos32   = 32'(req_tdata[POS_LSB +: POS_W]);
      right32 = 32'(req_tdata[RIGHT_LSB +: POS_W]);
      rsat32  = (right32 >= 32'(LEAVES)) ? 32'(LEAVES - 1) : right32;
      parent  = node_ff >> 1;
      upd_res = seg_combine(mode_ff, cur_ff, ram_rdata_a);
      lo_inc  = lo_ff + NW'(lo_ff[0]);
      hi_dec  = {hi_ff[NW-1:1], 1'b0};
      lo_nx   = lo_inc >> 1;
      hi_nx   = hi_ff >> 1;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      node_in      = node_ff;
      cur_in       = cur_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = node_ff;
      ram_wdata    = cur_ff;
      ram_raddr_a  = node_ff ^ AW'(1);
      ram_raddr_b  = '0;
      fold_ctl     = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == KIND_UPDATE) begin
                  node_in = AW'(pos32 + 32'(LEAVES));
                  cur_in  = req_tdata[VALUE_LSB +: DATA_W];
                  if (pos32 < 32'(LEAVES)) begin
                     state_in = ST_UPD_LEAF;
                  end
               end else begin
                  fold_ctl.init = 1'b1;
                  lo_in         = NW'(pos32 + 32'(LEAVES));
                  hi_in         = NW'(rsat32 + 32'(LEAVES + 1));
                  drain_in      = 1'b0;
                  state_in      = (pos32 > rsat32) ? ST_QRY_OUT : ST_QRY_WALK;
               end
            end
         end
         ST_UPD_LEAF: begin
            ram_we   = 1'b1;
            state_in = ST_UPD_WALK;
         end
         ST_UPD_WALK: begin
            ram_we      = 1'b1;
            ram_waddr   = parent;
            ram_wdata   = upd_res;
            ram_raddr_a = parent ^ AW'(1);
            cur_in      = upd_res;
            node_in     = parent;
            if (parent == AW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_QRY_WALK: begin
            ram_raddr_a     = lo_ff[AW-1:0];
            ram_raddr_b     = hi_ff[0] ? hi_dec[AW-1:0] : '0;
            fold_ctl.run    = 1'b1;
            fold_ctl.take_a = lo_ff[0];
            fold_ctl.take_b = hi_ff[0];
            lo_in           = lo_nx;
            hi_in           = hi_nx;
            if (!(lo_nx < hi_nx)) begin
               state_in = ST_QRY_DRAIN;
            end
         end
         ST_QRY_DRAIN: begin
            fold_ctl.run = 1'b1;
            drain_in     = 1'b1;
            if (drain_ff) begin
               state_in = ST_QRY_OUT;
            end
         end
         ST_QRY_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = fold_acc;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         drain_ff     <= 1'b0;
         mode_ff      <= MODE_SUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      cur_ff      <= cur_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request taken during clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD_WALK) |-> (node_ff > AW'(1)))
      else $error("update walk past the root");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QRY_WALK) |-> (lo_ff < hi_ff))
      else $error("query walk with empty range");

   assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != ST_CLEAR) |-> (ram_raddr_a != ram_waddr))
      else $error("node read and write collide");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_QRY_OUT))
      else $error("answer issued outside result state");
`endif

endmodule

// ----- tb/tb_segment_tree_point_update_range_query.sv -----
// Testbench for segment_tree_point_update_range_query: directed and random updates and queries
// under every combining mode, with random stalls on both streams, checked against a local tree.
// Depends on segtree_pkg and the segment tree RTL.
module tb_segment_tree_point_update_range_query;
   import segtree_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEAVES = DEF_LEAVES;
   localparam int PAD_W = REQ_DATA_W - (2 * POS_W + DATA_W);
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_PER_PHASE = 130;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [MODE_W-1:0] PHASE_MODES [6] =
      '{MODE_MAX, MODE_MIN, MODE_UNUSED, MODE_SUM, MODE_MIN, MODE_MAX};

   typedef struct {
      logic [POS_W-1:0]  left_end;
      logic [POS_W-1:0]  right_end;
      logic [DATA_W-1:0] answer;
   } answer_due_type;

   class range_fold_scoreboard;
      logic [DATA_W-1:0] nodes [2*LEAVES];
      logic [MODE_W-1:0] mode;
      answer_due_type    answers_due [$];
      int                errors;

      function new();
         foreach (nodes[i]) nodes[i] = '0;
         mode = MODE_SUM;
         errors = 0;
      endfunction

      function void set_mode(logic [MODE_W-1:0] m);
         mode = m;
      endfunction

      function int pending();
         return answers_due.size();
      endfunction

      function logic [DATA_W-1:0] empty_answer();
         if (mode == MODE_MAX) return MOST_NEG;
         if (mode == MODE_MIN) return MOST_POS;
         return '0;
      endfunction

      function logic [DATA_W-1:0] merge(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
         if (mode == MODE_MAX) return ($signed(b) > $signed(a)) ? b : a;
         if (mode == MODE_MIN) return ($signed(b) < $signed(a)) ? b : a;
         return a + b;
      endfunction

      function logic [DATA_W-1:0] fold_range(int left_end, int right_end);
         logic [DATA_W-1:0] acc;
         int lo;
         int hi;
         acc = empty_answer();
         if (right_end >= LEAVES) right_end = LEAVES - 1;
         if (left_end > right_end) return acc;
         lo = left_end + LEAVES;
         hi = right_end + 1 + LEAVES;
         while (lo < hi) begin
            if (lo % 2 == 1) begin
               acc = merge(acc, nodes[lo]);
               lo++;
            end
            if (hi % 2 == 1) begin
               hi--;
               acc = merge(acc, nodes[hi]);
            end
            lo = lo / 2;
            hi = hi / 2;
         end
         return acc;
      endfunction

      function void note_request(logic kind, logic [POS_W-1:0] left_end,
                                 logic [POS_W-1:0] right_end, logic [DATA_W-1:0] val);
         answer_due_type due;
         int node;
         if (kind == KIND_UPDATE) begin
            if (int'(left_end) >= LEAVES) return;
            node = int'(left_end) + LEAVES;
            nodes[node] = val;
            while (node > 1) begin
               node = node / 2;
               nodes[node] = merge(nodes[2*node], nodes[2*node+1]);
            end
         end else begin
            due.left_end = left_end;
            due.right_end = right_end;
            due.answer = fold_range(int'(left_end), int'(right_end));
            answers_due.insert(answers_due.size(), due);
         end
      endfunction

      task report(string msg);
         $display("%s", msg);
         errors++;
      endtask

      task check_answer(logic [DATA_W-1:0] got);
         answer_due_type due;
         if (answers_due.size() == 0) begin
            report($sformatf("unexpected answer %h", got));
            return;
         end
         due = answers_due.pop_front();
         if (got !== due.answer)
            report($sformatf("answer mismatch for range %0d..%0d mode %0d: expected %h got %h",
                             due.left_end, due.right_end, mode, due.answer, got));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // position[9:0], right_end[19:10], value[83:20]
   logic                  req_tuser = 1'b0;  // kind[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // answer[63:0]
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [MODE_W-1:0]     csr_wdata = '0;

   int req_gap_max = 6;
   int rsp_stall_max = 6;
   range_fold_scoreboard sb = new();

   segment_tree_point_update_range_query #(.LEAVES(LEAVES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin : watchdog
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic send(input logic kind, input logic [POS_W-1:0] left_end,
                       input logic [POS_W-1:0] right_end, input logic [DATA_W-1:0] val);
      int gap;
      logic seen;
      gap = (req_gap_max == 0) ? 0 : $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {{PAD_W{1'b0}}, val, right_end, left_end};
      do begin
         @(negedge clock);
         seen = req_tready;
         @(posedge clock);
      end while (seen !== 1'b1);
      sb.note_request(kind, left_end, right_end, val);
   endtask

   task automatic write_mode(input logic [MODE_W-1:0] mode);
      logic seen;
      csr_valid <= 1'b1;
      csr_wdata <= mode;
      do begin
         @(negedge clock);
         seen = csr_ready;
         @(posedge clock);
      end while (seen !== 1'b1);
      csr_valid <= 1'b0;
      sb.set_mode(mode);
   endtask

   // hold until every answer is back, then let a pending update finish its walk
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      int s;
      s = int'($urandom_range(0, 2000)) - 1000;
      case ($urandom_range(0, 7))
         0: return MOST_NEG;
         1: return MOST_POS;
         2: return '1;
         3: return {{32{s[31]}}, s};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_leaf();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return POS_W'(LEAVES - 1);
         2: return POS_W'($urandom_range(0, 15));
         default: return POS_W'($urandom_range(0, LEAVES - 1));
      endcase
   endfunction

   task automatic run_random(input int count);
      logic [POS_W-1:0] a;
      logic [POS_W-1:0] b;
      logic [POS_W-1:0] t;
      logic is_query;
      for (int n = 0; n < count; n++) begin
         is_query = ($urandom_range(0, 99) < 50);
         a = pick_leaf();
         b = pick_leaf();
         if (is_query && $urandom_range(0, 99) < 85 && a > b) begin
            t = a;
            a = b;
            b = t;
         end
         if (is_query && $urandom_range(0, 3) == 0)
            b = (a > POS_W'(LEAVES - 9)) ? POS_W'(LEAVES - 1) : a + POS_W'($urandom_range(0, 8));
         send(is_query ? KIND_QUERY : KIND_UPDATE, a, b, pick_value());
      end
   endtask

   initial begin : answer_sink
      int stall;
      logic seen;
      logic [RSP_DATA_W-1:0] got;
      @(negedge clock iff reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = (rsp_stall_max == 0) ? 0 : $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do begin
            @(negedge clock);
            seen = rsp_tvalid & rsp_tready;
            got = rsp_tdata;
            @(posedge clock);
         end while (seen !== 1'b1);
         sb.check_answer(got);
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_mode(MODE_SUM);
      send(KIND_QUERY,  10'd0,    10'd1023, '0);
      send(KIND_UPDATE, 10'd0,    10'd1023, MOST_POS);
      send(KIND_UPDATE, 10'd1023, 10'd0,    64'd1);
      send(KIND_QUERY,  10'd0,    10'd1023, '1);
      send(KIND_UPDATE, 10'd512,  10'd512,  MOST_NEG);
      send(KIND_QUERY,  10'd0,    10'd1023, '0);
      send(KIND_QUERY,  10'd0,    10'd0,    '0);
      send(KIND_QUERY,  10'd1023, 10'd1023, '0);
      send(KIND_QUERY,  10'd1023, 10'd0,    '0);
      send(KIND_QUERY,  10'd5,    10'd4,    '0);
      send(KIND_UPDATE, 10'd1,    10'd0,    '1);
      send(KIND_UPDATE, 10'd1022, 10'd1023, 64'h5555_5555_5555_5555);
      send(KIND_UPDATE, 10'd341,  10'd682,  64'haaaa_aaaa_aaaa_aaaa);
      send(KIND_QUERY,  10'd1,    10'd1022, '0);
      send(KIND_QUERY,  10'd341,  10'd341,  '0);
      send(KIND_QUERY,  10'd0,    10'd511,  '0);
      send(KIND_QUERY,  10'd512,  10'd1023, '0);

      settle();
      write_mode(MODE_MAX);
      send(KIND_QUERY,  10'd9,    10'd3,    '0);
      send(KIND_UPDATE, 10'd700,  10'd0,    MOST_NEG);
      send(KIND_QUERY,  10'd0,    10'd1023, '0);
      send(KIND_QUERY,  10'd700,  10'd700,  '0);

      settle();
      write_mode(MODE_MIN);
      send(KIND_QUERY,  10'd1000, 10'd999,  '0);
      send(KIND_UPDATE, 10'd3,    10'd0,    MOST_POS);
      send(KIND_QUERY,  10'd0,    10'd1023, '0);

      settle();
      write_mode(MODE_UNUSED);
      send(KIND_QUERY,  10'd2,    10'd1,    '0);
      send(KIND_QUERY,  10'd0,    10'd1023, '0);

      for (int p = 0; p < 6; p++) begin
         settle();
         write_mode(PHASE_MODES[p]);
         req_gap_max = (p == 1 || p == 2) ? 0 : 6;
         rsp_stall_max = (p == 1 || p == 4) ? 0 : 6;
         run_random(RANDOM_PER_PHASE);
      end

      settle();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/segtree_pkg.sv
sv/segtree_ram.sv
sv/segtree_fold.sv
sv/segment_tree_point_update_range_query.sv
tb/tb_segment_tree_point_update_range_query.sv
